[rtl/mmbb_pkg.sv]
// ---------------------------------------------------------------------------
// mmbb_pkg: shared types and constants for the minimum makespan scheduler
// Fixed field widths and the search sequencer state encoding.
// ---------------------------------------------------------------------------
package mmbb_pkg;

  localparam int unsigned SPAN_W = 21;  // makespan and machine load width
  localparam int unsigned MIDX_W = 5;   // machine index width
  localparam int unsigned MCNT_W = 5;   // machine count register width

  localparam logic [SPAN_W-1:0] SPAN_ALL_ONES = '1;

  typedef enum logic [13:0] {
    ST_IDLE    = 14'h0001,
    ST_CLEAR   = 14'h0002,
    ST_INIT    = 14'h0004,
    ST_ENTER   = 14'h0008,
    ST_BACK    = 14'h0010,
    ST_BK_LD   = 14'h0020,
    ST_BK_WR   = 14'h0040,
    ST_SCAN_RD = 14'h0080,
    ST_SCAN_CK = 14'h0100,
    ST_CP_RD   = 14'h0200,
    ST_CP_WR   = 14'h0400,
    ST_OUT_RD  = 14'h0800,
    ST_OUT_LD  = 14'h1000,
    ST_OUT_WT  = 14'h2000
  } state_e;

  typedef struct packed {
    logic insert;  // store one job
    logic clear;   // empty the store
  } sort_ctl_t;

endpackage

[rtl/mmbb_sorter.sv]
// ---------------------------------------------------------------------------
// mmbb_sorter: descending job store
// Register row that shifts on insertion; one read port by index.
// ---------------------------------------------------------------------------
module mmbb_sorter
  import mmbb_pkg::*;
#(
  parameter int unsigned MAX_TASKS  = 20,
  parameter int unsigned TIME_WIDTH = 16,
  localparam int unsigned NW = $clog2(MAX_TASKS + 1),
  localparam int unsigned IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sort_ctl_t             ctl_i,
  input  logic [TIME_WIDTH-1:0] job_i,
  input  logic [IW-1:0]         rd_idx_i,
  output logic [TIME_WIDTH-1:0] rd_job_o,
  output logic [NW-1:0]         count_o
);

  logic [TIME_WIDTH-1:0] jobs_q [MAX_TASKS];
  logic [TIME_WIDTH-1:0] jobs_d [MAX_TASKS];
  logic [MAX_TASKS-1:0]  shift;
  logic [NW-1:0]         count_q;
  logic                  room;

  assign room = (count_q < NW'(MAX_TASKS));

  // an entry moves down when it is smaller than the new job; the free slot takes part too
  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      shift[i] = ((NW'(i) < count_q) && (jobs_q[i] < job_i)) || (NW'(i) == count_q);
    end
    for (int i = 0; i < MAX_TASKS; i++) begin
      jobs_d[i] = jobs_q[i];
      if (shift[i]) begin
        if (i > 0 && shift[(i > 0) ? i - 1 : 0]) begin
          jobs_d[i] = jobs_q[(i > 0) ? i - 1 : 0];
        end else begin
          jobs_d[i] = job_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.insert && room) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        jobs_q[i] <= jobs_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctl_i.clear) begin
      count_q <= '0;
    end else if (ctl_i.insert && room) begin
      count_q <= count_q + NW'(1);
    end
  end

  assign rd_job_o = jobs_q[rd_idx_i];
  assign count_o  = count_q;

endmodule

[rtl/min_makespan_branch_bound_top.sv]
// ---------------------------------------------------------------------------
// min_makespan_branch_bound_top: minimum makespan scheduler
// Sorted job store plus a depth-first branch-and-bound search sequencer.
// ---------------------------------------------------------------------------
// Usage:
//   Jobs arrive on the s_axis channel, one transfer per cycle while idle;
//   tlast marks the final job of a set. Jobs beyond MAX_TASKS are dropped.
//   The machine count is written through cfg_we_i / cfg_wdata_i; the user
//   must write it only while idle, the block does not enforce this. After
//   the final job the block clears its load and best-assignment memories,
//   then searches: each machine tried at a level is read and checked, each
//   backtrack reloads the level and undoes its load, and a better schedule
//   is copied entry by entry; search length depends on the data. Results
//   then leave on m_axis, one transfer per sorted job (longest first), each
//   held until the receiver takes it, tlast on the final one.
//   s_axis_tready is low from the final job until the last result is taken.
//   A stalled receiver simply holds the result register.
//   Reset empties the store, sets the machine count to 1 and goes idle.
// ---------------------------------------------------------------------------
module min_makespan_branch_bound_top
  import mmbb_pkg::*;
#(
  parameter int unsigned MAX_TASKS    = 20,
  parameter int unsigned MAX_MACHINES = 20,
  parameter int unsigned TIME_WIDTH   = 16,
  localparam int unsigned IDW = ((TIME_WIDTH + 7) / 8) * 8,
  localparam int unsigned ODW = ((TIME_WIDTH + MIDX_W + SPAN_W + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [MCNT_W-1:0] cfg_wdata_i,    // machine_count
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IDW-1:0]    s_axis_tdata,   // job_time
  input  logic              s_axis_tlast,   // last_job
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [ODW-1:0]    m_axis_tdata,   // job_duration, machine_index, makespan
  output logic              m_axis_tlast    // last_result
);

  localparam int unsigned NW    = $clog2(MAX_TASKS + 1);
  localparam int unsigned IW    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned KW    = $clog2(MAX_MACHINES + 1);
  localparam int unsigned MAW   = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int unsigned CLR_N = (MAX_TASKS > MAX_MACHINES) ? MAX_TASKS : MAX_MACHINES;
  localparam int unsigned CW    = $clog2(CLR_N + 1);
  localparam int unsigned LVW   = MIDX_W + KW + SPAN_W;

  state_e state_q, state_d;

  logic [MCNT_W-1:0] mcnt_q;
  logic [KW-1:0]     k_q, k_d;
  logic [NW-1:0]     n_q, n_d;
  logic [NW-1:0]     d_q, d_d;
  logic [KW-1:0]     i_q, i_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [SPAN_W-1:0] max_q, max_d;
  logic [SPAN_W-1:0] best_q, best_d;
  logic [MIDX_W-1:0] tr_q, tr_d;

  // job store
  sort_ctl_t             sctl;
  logic [IW-1:0]         srd_idx;
  logic [TIME_WIDTH-1:0] job;
  logic [NW-1:0]         count;

  // machine loads
  logic [SPAN_W-1:0] load_mem [MAX_MACHINES];
  logic              ld_we, ld_re;
  logic [MAW-1:0]    ld_waddr, ld_raddr;
  logic [SPAN_W-1:0] ld_wdata, ld_rdata_q;

  // per level: trial machine, next machine to try, running max of that level
  logic [LVW-1:0]    lvl_mem [MAX_TASKS];
  logic              lv_we, lv_re;
  logic [IW-1:0]     lv_waddr, lv_raddr;
  logic [LVW-1:0]    lv_wdata, lv_rdata_q;
  logic [MIDX_W-1:0] lv_trial;
  logic [KW-1:0]     lv_next;
  logic [SPAN_W-1:0] lv_max;

  // best assignment
  logic [MIDX_W-1:0] best_mem [MAX_TASKS];
  logic              bm_we, bm_re;
  logic [IW-1:0]     bm_waddr, bm_raddr;
  logic [MIDX_W-1:0] bm_wdata, bm_rdata_q;

  logic [ODW-1:0] m_data_q, m_data_d;
  logic           m_valid_q, m_valid_d, m_last_q, m_last_d;

  logic            in_xfer;
  logic [SPAN_W:0] sum;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  assign lv_trial = lv_rdata_q[LVW-1 -: MIDX_W];
  assign lv_next  = lv_rdata_q[SPAN_W +: KW];
  assign lv_max   = lv_rdata_q[SPAN_W-1:0];
  assign sum      = {1'b0, ld_rdata_q} + (SPAN_W + 1)'(job);

  mmbb_sorter #(
    .MAX_TASKS (MAX_TASKS),
    .TIME_WIDTH(TIME_WIDTH)
  ) u_sorter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (sctl),
    .job_i   (s_axis_tdata[TIME_WIDTH-1:0]),
    .rd_idx_i(srd_idx),
    .rd_job_o(job),
    .count_o (count)
  );

  always_comb begin
    srd_idx = d_q[IW-1:0];
    if (state_q == ST_OUT_RD || state_q == ST_OUT_LD || state_q == ST_OUT_WT) begin
      srd_idx = cnt_q[IW-1:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    n_d       = n_q;
    d_d       = d_q;
    i_d       = i_q;
    cnt_d     = cnt_q;
    max_d     = max_q;
    best_d    = best_q;
    tr_d      = tr_q;
    m_data_d  = m_data_q;
    m_valid_d = m_valid_q;
    m_last_d  = m_last_q;
    sctl      = '{insert: in_xfer, clear: 1'b0};
    ld_we     = 1'b0;
    ld_re     = 1'b0;
    ld_waddr  = '0;
    ld_raddr  = '0;
    ld_wdata  = '0;
    lv_we     = 1'b0;
    lv_re     = 1'b0;
    lv_waddr  = '0;
    lv_raddr  = '0;
    lv_wdata  = '0;
    bm_we     = 1'b0;
    bm_re     = 1'b0;
    bm_waddr  = '0;
    bm_raddr  = '0;
    bm_wdata  = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && s_axis_tlast) begin
          n_d    = (count < NW'(MAX_TASKS)) ? count + NW'(1) : count;
          best_d = SPAN_ALL_ONES;
          cnt_d  = '0;
          d_d    = '0;
          if (mcnt_q == '0) begin
            k_d = KW'(1);
          end else if (32'(mcnt_q) > MAX_MACHINES) begin
            k_d = KW'(MAX_MACHINES);
          end else begin
            k_d = KW'(mcnt_q);
          end
          state_d = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (32'(cnt_q) < MAX_MACHINES) begin
          ld_we    = 1'b1;
          ld_waddr = cnt_q[MAW-1:0];
        end
        if (32'(cnt_q) < MAX_TASKS) begin
          bm_we    = 1'b1;
          bm_waddr = cnt_q[IW-1:0];
        end
        cnt_d = cnt_q + CW'(1);
        if (32'(cnt_q) == CLR_N - 1) begin
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        // first job fixed on machine 0
        ld_we    = 1'b1;
        ld_wdata = SPAN_W'(job);
        lv_we    = 1'b1;
        max_d    = SPAN_W'(job);
        d_d      = NW'(1);
        state_d  = ST_ENTER;
      end
      ST_ENTER: begin
        if (d_q >= n_q) begin
          if (max_q < best_q) begin
            best_d  = max_q;
            cnt_d   = '0;
            state_d = ST_CP_RD;
          end else begin
            state_d = ST_BACK;
          end
        end else if (max_q >= best_q) begin
          state_d = ST_BACK;
        end else begin
          i_d     = '0;
          state_d = ST_SCAN_RD;
        end
      end
      ST_BACK: begin
        if (d_q <= NW'(1)) begin
          cnt_d   = '0;
          state_d = ST_OUT_RD;
        end else begin
          d_d      = d_q - NW'(1);
          lv_re    = 1'b1;
          lv_raddr = d_d[IW-1:0];
          state_d  = ST_BK_LD;
        end
      end
      ST_BK_LD: begin
        max_d    = lv_max;
        i_d      = lv_next;
        tr_d     = lv_trial;
        ld_re    = 1'b1;
        ld_raddr = lv_trial[MAW-1:0];
        state_d  = ST_BK_WR;
      end
      ST_BK_WR: begin
        // undo this level's placement
        ld_we    = 1'b1;
        ld_waddr = tr_q[MAW-1:0];
        ld_wdata = ld_rdata_q - SPAN_W'(job);
        state_d  = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        if (i_q >= k_q) begin
          state_d = ST_BACK;
        end else begin
          ld_re    = 1'b1;
          ld_raddr = i_q[MAW-1:0];
          state_d  = ST_SCAN_CK;
        end
      end
      ST_SCAN_CK: begin
        if (sum <= {1'b0, best_q}) begin
          ld_we    = 1'b1;
          ld_waddr = i_q[MAW-1:0];
          ld_wdata = sum[SPAN_W-1:0];
          lv_we    = 1'b1;
          lv_waddr = d_q[IW-1:0];
          lv_wdata = {MIDX_W'(i_q), i_q + KW'(1), max_q};
          max_d    = (sum[SPAN_W-1:0] > max_q) ? sum[SPAN_W-1:0] : max_q;
          d_d      = d_q + NW'(1);
          state_d  = ST_ENTER;
        end else begin
          i_d     = i_q + KW'(1);
          state_d = ST_SCAN_RD;
        end
      end
      ST_CP_RD: begin
        lv_re    = 1'b1;
        lv_raddr = cnt_q[IW-1:0];
        state_d  = ST_CP_WR;
      end
      ST_CP_WR: begin
        bm_we    = 1'b1;
        bm_waddr = cnt_q[IW-1:0];
        bm_wdata = lv_trial;
        cnt_d    = cnt_q + CW'(1);
        state_d  = (cnt_d == CW'(n_q)) ? ST_BACK : ST_CP_RD;
      end
      ST_OUT_RD: begin
        bm_re    = 1'b1;
        bm_raddr = cnt_q[IW-1:0];
        state_d  = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        m_data_d  = ODW'({best_q, bm_rdata_q, job});
        m_last_d  = (cnt_q + CW'(1) == CW'(n_q));
        m_valid_d = 1'b1;
        state_d   = ST_OUT_WT;
      end
      ST_OUT_WT: begin
        if (m_axis_tready) begin
          m_valid_d = 1'b0;
          if (m_last_q) begin
            sctl.clear = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            cnt_d   = cnt_q + CW'(1);
            state_d = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mcnt_q    <= MCNT_W'(1);
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        mcnt_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    n_q      <= n_d;
    d_q      <= d_d;
    i_q      <= i_d;
    cnt_q    <= cnt_d;
    max_q    <= max_d;
    best_q   <= best_d;
    tr_q     <= tr_d;
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (ld_we) begin
      load_mem[ld_waddr] <= ld_wdata;
    end
    if (ld_re) begin
      ld_rdata_q <= load_mem[ld_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (lv_we) begin
      lvl_mem[lv_waddr] <= lv_wdata;
    end
    if (lv_re) begin
      lv_rdata_q <= lvl_mem[lv_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (bm_we) begin
      best_mem[bm_waddr] <= bm_wdata;
    end
    if (bm_re) begin
      bm_rdata_q <= best_mem[bm_raddr];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  a_valid_only_when_waiting: assert property (
    @(posedge clk_i) disable iff (!rst_ni) m_axis_tvalid |-> (state_q == ST_OUT_WT)
  ) else $error("result valid outside output wait");

  a_depth_in_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == ST_ENTER) |-> (d_q >= NW'(1) && d_q <= n_q)
  ) else $error("search depth out of range");

  a_best_never_grows: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == ST_BACK && $past(state_q) == ST_ENTER) |-> (best_q <= $past(best_q))
  ) else $error("best makespan increased");

  a_scan_within_k: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (state_q == ST_SCAN_CK) |-> (i_q < k_q)
  ) else $error("machine scan past machine count");

endmodule
